### rtl/blm_pkg.sv
// Shared package of the battery level monitor: widths, register indexes,
// level codes, limit tables and the structs between controller and datapath.
// No dependencies.
package blm_pkg;

  // Batch size; the batch sum keeps 17 bits, so up to 32 samples fit.
  localparam int unsigned SamplesPerReport = 30;

  localparam int unsigned SampleW = 12;
  localparam int unsigned SumW    = 17;
  localparam int unsigned CountW  = 5;
  localparam int unsigned AvgW    = 12;
  localparam int unsigned MvW     = 14;
  localparam int unsigned EmaW    = 22;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned PctW    = 7;
  localparam int unsigned LimW    = 9;
  localparam int unsigned ScaleW  = 18;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned HystW   = 10;

  // Mean by reciprocal multiply: exact for any 17-bit sum and batch size <= 32.
  localparam int unsigned AvgShift  = 22;
  localparam int unsigned RecipW    = 23;
  localparam int unsigned AvgProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] AvgRecip =
    RecipW'(((64'd1 << AvgShift) + 64'(SamplesPerReport) - 64'd1) / 64'(SamplesPerReport));

  localparam int unsigned MvProdW = AvgW + ScaleW;
  localparam int unsigned FiltProdW = AlphaW + EmaW;
  localparam int unsigned NumW    = 29;
  localparam int unsigned DivSteps = 7;
  localparam int unsigned DivIdxW  = 3;
  localparam logic [PctW-1:0] PctFull = 7'd100;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 18;
  localparam logic [CfgIdxW-1:0] RegScale    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegAlpha    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegWarnOn   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegCritOn   = 8'd3;
  localparam logic [CfgIdxW-1:0] RegShdOn    = 8'd4;
  localparam logic [CfgIdxW-1:0] RegHyst     = 8'd5;
  localparam logic [CfgIdxW-1:0] RegEmpty    = 8'd6;
  localparam logic [CfgIdxW-1:0] RegFull     = 8'd7;

  // Level codes
  localparam logic [LevelW-1:0] LvlOk       = 2'd0;
  localparam logic [LevelW-1:0] LvlWarn     = 2'd1;
  localparam logic [LevelW-1:0] LvlCrit     = 2'd2;
  localparam logic [LevelW-1:0] LvlShutdown = 2'd3;

  // Motion limits per level, Q8
  localparam logic [LimW-1:0] LimSpeed [4] = '{9'd256, 9'd179, 9'd102, 9'd0};
  localparam logic [LimW-1:0] LimAccel [4] = '{9'd256, 9'd154, 9'd77,  9'd0};
  localparam logic [LimW-1:0] LimPwm   [4] = '{9'd256, 9'd179, 9'd102, 9'd0};

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [AlphaW-1:0] alpha;
    logic [MvW-1:0]    warn_on;
    logic [MvW-1:0]    crit_on;
    logic [MvW-1:0]    shd_on;
    logic [HystW-1:0]  hyst;
    logic [MvW-1:0]    empty;
    logic [MvW-1:0]    full;
  } cfg_t;

  typedef struct packed {
    logic [AvgW-1:0]   adc_average;
    logic [MvW-1:0]    battery_mv;
    logic [MvW-1:0]    filtered_mv;
    logic [LevelW-1:0] level;
    logic [PctW-1:0]   percent;
    logic [LimW-1:0]   speed_limit;
    logic [LimW-1:0]   accel_limit;
    logic [LimW-1:0]   max_pwm;
    logic              report_valid;
  } out_item_t;

  typedef struct packed {
    logic accept;    // request taken this cycle
    logic avg_en;    // batch mean
    logic mv_en;     // millivolt scaling
    logic fprod_en;  // filter product
    logic fupd_en;   // filter update
    logic pct_en;    // level step and percent set-up
    logic div_en;    // one percent division step
    logic load_out;  // fill output register
    logic fallback;  // output register takes the failure report
  } dp_cmd_t;

  typedef struct packed {
    logic read_failed;
    logic last_sample;
    logic div_last;
  } dp_status_t;

endpackage

### rtl/blm_ifs.sv
// Channel interfaces of the battery level monitor: sample input, report output
// and register write. Depends on blm_pkg.
interface blm_in_if;
  import blm_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               read_failed;
  modport source (output valid, output sample, output read_failed, input ready);
  modport sink   (input valid, input sample, input read_failed, output ready);
endinterface

interface blm_out_if;
  import blm_pkg::*;
  logic              valid;
  logic              ready;
  logic [AvgW-1:0]   adc_average;
  logic [MvW-1:0]    battery_mv;
  logic [MvW-1:0]    filtered_mv;
  logic [LevelW-1:0] level;
  logic [PctW-1:0]   percent;
  logic [LimW-1:0]   speed_limit;
  logic [LimW-1:0]   accel_limit;
  logic [LimW-1:0]   max_pwm;
  logic              report_valid;
  modport source (output valid, output adc_average, output battery_mv, output filtered_mv,
                  output level, output percent, output speed_limit, output accel_limit,
                  output max_pwm, output report_valid, input ready);
  modport sink   (input valid, input adc_average, input battery_mv, input filtered_mv,
                  input level, input percent, input speed_limit, input accel_limit,
                  input max_pwm, input report_valid, output ready);
endinterface

interface blm_cfg_if;
  import blm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/blm_regs.sv
// Configuration register file of the battery level monitor.
// Depends on blm_pkg and blm_cfg_if.
module blm_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  blm_cfg_if.sink       cfg_i,
  output blm_pkg::cfg_t cfg_o
);
  import blm_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Out-of-range indexes are dropped; data is cut to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale   <= 18'd212853;
      cfg_q.alpha   <= 17'd3277;
      cfg_q.warn_on <= 14'd10500;
      cfg_q.crit_on <= 14'd9900;
      cfg_q.shd_on  <= 14'd9600;
      cfg_q.hyst    <= 10'd200;
      cfg_q.empty   <= 14'd9600;
      cfg_q.full    <= 14'd12600;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        RegScale:  cfg_q.scale   <= cfg_i.wdata[ScaleW-1:0];
        RegAlpha:  cfg_q.alpha   <= cfg_i.wdata[AlphaW-1:0];
        RegWarnOn: cfg_q.warn_on <= cfg_i.wdata[MvW-1:0];
        RegCritOn: cfg_q.crit_on <= cfg_i.wdata[MvW-1:0];
        RegShdOn:  cfg_q.shd_on  <= cfg_i.wdata[MvW-1:0];
        RegHyst:   cfg_q.hyst    <= cfg_i.wdata[HystW-1:0];
        RegEmpty:  cfg_q.empty   <= cfg_i.wdata[MvW-1:0];
        RegFull:   cfg_q.full    <= cfg_i.wdata[MvW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/blm_ctrl.sv
// Controller of the battery level monitor: sequences one batch-end
// computation and owns the output valid flag. Depends on blm_pkg.
module blm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  blm_pkg::dp_status_t status_i,
  output blm_pkg::dp_cmd_t    cmd_o
);
  import blm_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StAvg, StMv, StFprod, StFupd, StPct, StDiv, StEmit
  } state_e;

  state_e state_q;
  logic   fallback_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:  cmd_o.accept   = in_valid_i;
      StAvg:   cmd_o.avg_en   = 1'b1;
      StMv:    cmd_o.mv_en    = 1'b1;
      StFprod: cmd_o.fprod_en = 1'b1;
      StFupd:  cmd_o.fupd_en  = 1'b1;
      StPct:   cmd_o.pct_en   = 1'b1;
      StDiv:   cmd_o.div_en   = 1'b1;
      StEmit: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
        cmd_o.fallback = fallback_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fallback_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (status_i.read_failed) begin
              fallback_q <= 1'b1;
              state_q    <= StEmit;
            end else if (status_i.last_sample) begin
              fallback_q <= 1'b0;
              state_q    <= StAvg;
            end
          end
        end
        StAvg:   state_q <= StMv;
        StMv:    state_q <= StFprod;
        StFprod: state_q <= StFupd;
        StFupd:  state_q <= StPct;
        StPct:   state_q <= StDiv;
        StDiv: begin
          if (status_i.div_last) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (cmd_o.load_out) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### rtl/blm_dp.sv
// Datapath of the battery level monitor: batch accumulator, mean, scaling,
// EMA filter, hysteresis level, percent divider, output register. Depends on blm_pkg.
module blm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [blm_pkg::SampleW-1:0] sample_i,
  input  logic                       read_failed_i,
  input  blm_pkg::cfg_t              cfg_i,
  input  blm_pkg::dp_cmd_t           cmd_i,
  output blm_pkg::dp_status_t        status_o,
  output blm_pkg::out_item_t         out_o
);
  import blm_pkg::*;

  // Architectural state
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [EmaW-1:0]   ema_q, ema_d;
  logic              loaded_q;
  logic [LevelW-1:0] level_q, level_d;

  // Work registers
  logic [AvgW-1:0]      avg_q;
  logic [MvW-1:0]       mv_q;
  logic [FiltProdW-1:0] fprod_q;
  logic                 rising_q;
  logic [NumW-1:0]      rem_q;
  logic [EmaW-1:0]      span_q;
  logic [PctW-1:0]      quot_q;
  logic [DivIdxW-1:0]   div_idx_q;
  logic                 pct_zero_q, pct_full_q;
  out_item_t            out_q;

  logic                 last;
  logic [AvgProdW-1:0]  avg_prod;
  logic [MvProdW-1:0]   mv_prod;
  logic [AlphaW-1:0]    alpha_eff;
  logic [EmaW-1:0]      x_val, diff;
  logic [FiltProdW-1:0] dec_round;
  logic [EmaW-1:0]      empty8, full8, span;
  logic [NumW-1:0]      num, trial;
  logic [EmaW:0]        f_ext, warn8, crit8, shd8, warn_up, crit_up, shd_up;
  logic [PctW-1:0]      pct;

  assign last = (count_q == CountW'(SamplesPerReport - 1));

  assign status_o.read_failed = read_failed_i;
  assign status_o.last_sample = last;
  assign status_o.div_last    = (div_idx_q == '0);

  // Mean and millivolts; 12 x 18 bits >> 16 never passes 16383.
  assign avg_prod = AvgProdW'(sum_q) * AvgProdW'(AvgRecip);
  assign mv_prod  = MvProdW'(avg_q) * MvProdW'(cfg_i.scale);

  // Filter
  assign alpha_eff = cfg_i.alpha[AlphaW-1] ? {1'b1, {(AlphaW-1){1'b0}}} : cfg_i.alpha;
  assign x_val     = {mv_q, 8'b0};
  assign diff      = (x_val >= ema_q) ? (x_val - ema_q) : (ema_q - x_val);
  assign dec_round = fprod_q + FiltProdW'(16'hFFFF);

  always_comb begin
    if (!loaded_q) begin
      ema_d = x_val;
    end else if (rising_q) begin
      ema_d = ema_q + EmaW'(fprod_q[FiltProdW-1:16]);
    end else begin
      ema_d = ema_q - EmaW'(dec_round[FiltProdW-1:16]);
    end
  end

  // Hysteresis, compared in Q8
  assign f_ext   = {1'b0, ema_q};
  assign warn8   = {1'b0, cfg_i.warn_on, 8'b0};
  assign crit8   = {1'b0, cfg_i.crit_on, 8'b0};
  assign shd8    = {1'b0, cfg_i.shd_on, 8'b0};
  assign warn_up = {({1'b0, cfg_i.warn_on} + (MvW+1)'(cfg_i.hyst)), 8'b0};
  assign crit_up = {({1'b0, cfg_i.crit_on} + (MvW+1)'(cfg_i.hyst)), 8'b0};
  assign shd_up  = {({1'b0, cfg_i.shd_on} + (MvW+1)'(cfg_i.hyst)), 8'b0};

  always_comb begin
    level_d = level_q;
    case (level_q)
      LvlOk: begin
        if (f_ext < warn8) level_d = LvlWarn;
      end
      LvlWarn: begin
        if (f_ext < crit8) level_d = LvlCrit;
        else if (f_ext > warn_up) level_d = LvlOk;
      end
      LvlCrit: begin
        if (f_ext < shd8) level_d = LvlShutdown;
        else if (f_ext > crit_up) level_d = LvlWarn;
      end
      default: begin
        if (f_ext > shd_up) level_d = LvlCrit;
      end
    endcase
  end

  // Percent set-up and restoring division, one quotient bit per step
  assign empty8 = {cfg_i.empty, 8'b0};
  assign full8  = {cfg_i.full, 8'b0};
  assign span   = full8 - empty8;
  assign num    = NumW'(ema_q - empty8) * NumW'(PctFull) + NumW'(span >> 1);
  assign trial  = NumW'(span_q) << div_idx_q;
  assign pct    = pct_zero_q ? '0 : (pct_full_q ? PctFull : quot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      count_q  <= '0;
      ema_q    <= '0;
      loaded_q <= 1'b0;
      level_q  <= LvlOk;
    end else begin
      if (cmd_i.accept) begin
        if (read_failed_i) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_q + SumW'(sample_i);
          count_q <= last ? '0 : count_q + 1'b1;
        end
      end
      if (cmd_i.avg_en) begin
        sum_q <= '0;
      end
      if (cmd_i.fupd_en) begin
        ema_q    <= ema_d;
        loaded_q <= 1'b1;
      end
      if (cmd_i.pct_en) begin
        level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_en) begin
      avg_q <= avg_prod[AvgShift +: AvgW];
    end
    if (cmd_i.mv_en) begin
      mv_q <= mv_prod[MvProdW-1:16];
    end
    if (cmd_i.fprod_en) begin
      fprod_q  <= FiltProdW'(alpha_eff) * FiltProdW'(diff);
      rising_q <= (x_val >= ema_q);
    end
    if (cmd_i.pct_en) begin
      pct_zero_q <= (cfg_i.full <= cfg_i.empty) || (ema_q <= empty8);
      pct_full_q <= (ema_q >= full8);
      span_q     <= span;
      rem_q      <= num;
      quot_q     <= '0;
      div_idx_q  <= DivIdxW'(DivSteps - 1);
    end
    if (cmd_i.div_en) begin
      if (rem_q >= trial) begin
        rem_q             <= rem_q - trial;
        quot_q[div_idx_q] <= 1'b1;
      end
      div_idx_q <= div_idx_q - 1'b1;
    end
    if (cmd_i.load_out) begin
      if (cmd_i.fallback) begin
        out_q.adc_average  <= '0;
        out_q.battery_mv   <= '0;
        out_q.filtered_mv  <= '0;
        out_q.level        <= LvlOk;
        out_q.percent      <= '0;
        out_q.speed_limit  <= LimSpeed[LvlOk];
        out_q.accel_limit  <= LimAccel[LvlOk];
        out_q.max_pwm      <= LimPwm[LvlOk];
        out_q.report_valid <= 1'b0;
      end else begin
        out_q.adc_average  <= avg_q;
        out_q.battery_mv   <= mv_q;
        out_q.filtered_mv  <= ema_q[EmaW-1:8];
        out_q.level        <= level_q;
        out_q.percent      <= pct;
        out_q.speed_limit  <= LimSpeed[level_q];
        out_q.accel_limit  <= LimAccel[level_q];
        out_q.max_pwm      <= LimPwm[level_q];
        out_q.report_valid <= 1'b1;
      end
    end
  end

  assign out_o = out_q;

endmodule

### rtl/battery_level_monitor_core.sv
// Battery level monitor, top level: register file, controller and datapath.
// Depends on blm_pkg, blm_ifs, blm_regs, blm_ctrl and blm_dp.
//
// Use:
//   in_i   - one request per raw ADC sample (sample, read_failed).
//   out_o  - one report per completed batch of SamplesPerReport good samples,
//            or a fallback report (report_valid 0) at once for a failed read.
//   cfg_i  - register writes (index 0..7), always ready; write only when idle.
// Sequence:
//   A sample that does not close a batch is accumulated; in_ready stays
//   high. A batch-closing sample runs mean, scaling, filter product, filter
//   update, level/percent set-up and a 7-step restoring divider (one quotient
//   bit per cycle), then loads the report into the output register; in_ready
//   is low meanwhile. A failed read goes straight to loading its fallback report.
// Reset: batch, filter (unloaded) and level (ok) clear; registers take their
//   defaults; no report pending.
// Stall: the output register holds a report until taken; further samples are
//   still accumulated, and the next report waits in its final state.
module battery_level_monitor_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  blm_in_if.sink   in_i,
  blm_out_if.source out_o,
  blm_cfg_if.sink  cfg_i
);
  import blm_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  item;

  blm_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  blm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  blm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (in_i.sample),
    .read_failed_i (in_i.read_failed),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_o         (item)
  );

  // Report fields straight from the output register
  assign out_o.adc_average  = item.adc_average;
  assign out_o.battery_mv   = item.battery_mv;
  assign out_o.filtered_mv  = item.filtered_mv;
  assign out_o.level        = item.level;
  assign out_o.percent      = item.percent;
  assign out_o.speed_limit  = item.speed_limit;
  assign out_o.accel_limit  = item.accel_limit;
  assign out_o.max_pwm      = item.max_pwm;
  assign out_o.report_valid = item.report_valid;

endmodule

### test/blm_checker.sv
// Scoreboard for the battery level monitor: watches the sample, report and
// register channels, predicts every report and compares it field by field.
// Depends on blm_pkg and the channel interfaces in blm_ifs.
module blm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  blm_in_if           in_mon,
  blm_out_if          out_mon,
  blm_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import blm_pkg::*;

  localparam logic [ScaleW-1:0] ScaleReset = 18'd212853;
  localparam logic [AlphaW-1:0] AlphaReset = 17'd3277;
  localparam logic [MvW-1:0]    WarnReset  = 14'd10500;
  localparam logic [MvW-1:0]    CritReset  = 14'd9900;
  localparam logic [MvW-1:0]    ShdReset   = 14'd9600;
  localparam logic [HystW-1:0]  HystReset  = 10'd200;
  localparam logic [MvW-1:0]    EmptyReset = 14'd9600;
  localparam logic [MvW-1:0]    FullReset  = 14'd12600;
  localparam logic [63:0]       MvCeiling  = 64'd16383;
  localparam logic [63:0]       AlphaOne   = 64'd65536;

  // Q8 motion limits per level: ok, warn, critical, shutdown
  localparam logic [LimW-1:0] SpeedQ8 [4] = '{9'd256, 9'd179, 9'd102, 9'd0};
  localparam logic [LimW-1:0] AccelQ8 [4] = '{9'd256, 9'd154, 9'd77,  9'd0};
  localparam logic [LimW-1:0] PwmQ8   [4] = '{9'd256, 9'd179, 9'd102, 9'd0};

  logic [ScaleW-1:0] scale_q;
  logic [AlphaW-1:0] alpha_q;
  logic [MvW-1:0]    warn_q, crit_q, shd_q, empty_q, full_q;
  logic [HystW-1:0]  hyst_q;

  logic [SumW-1:0]   batch_sum;
  logic [CountW-1:0] batch_count;
  logic [EmaW-1:0]   ema_q8;
  logic              ema_primed;
  logic [LevelW-1:0] level_q;

  out_item_t   pending_reports[$];
  int unsigned mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  function automatic logic [LevelW-1:0] next_level(input logic [LevelW-1:0] lvl,
                                                   input logic [EmaW-1:0] f8);
    logic [31:0] f, warn8, crit8, shd8, h;
    f     = 32'(f8);
    h     = 32'(hyst_q);
    warn8 = 32'(warn_q) << 8;
    crit8 = 32'(crit_q) << 8;
    shd8  = 32'(shd_q) << 8;
    case (lvl)
      LvlOk: begin
        if (f < warn8) return LvlWarn;
      end
      LvlWarn: begin
        if (f < crit8) return LvlCrit;
        else if (f > ((32'(warn_q) + h) << 8)) return LvlOk;
      end
      LvlCrit: begin
        if (f < shd8) return LvlShutdown;
        else if (f > ((32'(crit_q) + h) << 8)) return LvlWarn;
      end
      default: begin
        // shutdown only ever climbs
        if (f > ((32'(shd_q) + h) << 8)) return LvlCrit;
      end
    endcase
    return lvl;
  endfunction

  function automatic logic [PctW-1:0] charge_percent(input logic [EmaW-1:0] f8);
    logic [63:0] f, lo, hi, span;
    f  = 64'(f8);
    lo = 64'(empty_q) << 8;
    hi = 64'(full_q) << 8;
    if (full_q <= empty_q || f <= lo) return '0;
    if (f >= hi) return 7'd100;
    span = hi - lo;
    return PctW'(((f - lo) * 64'd100 + span / 2) / span);
  endfunction

  // Folds one sample request into the batch; returns 1 when a report is due.
  function automatic bit take_sample(input logic [SampleW-1:0] smp, input logic failed,
                                     output out_item_t rep);
    logic [63:0] avg, mv, x, e, a;
    rep = '0;
    if (failed) begin
      batch_sum   = '0;
      batch_count = '0;
      rep.level       = LvlOk;
      rep.speed_limit = SpeedQ8[LvlOk];
      rep.accel_limit = AccelQ8[LvlOk];
      rep.max_pwm     = PwmQ8[LvlOk];
      return 1'b1;
    end
    batch_sum   = batch_sum + SumW'(smp);
    batch_count = batch_count + 1'b1;
    if (batch_count < CountW'(SamplesPerReport)) return 1'b0;

    avg = 64'(batch_sum) / 64'(SamplesPerReport);
    batch_sum   = '0;
    batch_count = '0;
    mv = (avg * 64'(scale_q)) >> 16;
    if (mv > MvCeiling) mv = MvCeiling;

    x = mv << 8;
    a = (64'(alpha_q) > AlphaOne) ? AlphaOne : 64'(alpha_q);
    e = 64'(ema_q8);
    if (!ema_primed) begin
      e = x;
      ema_primed = 1'b1;
    end else if (x >= e) begin
      e = e + ((a * (x - e)) >> 16);
    end else begin
      e = e - ((a * (e - x) + 64'd65535) >> 16);
    end
    ema_q8  = e[EmaW-1:0];
    level_q = next_level(level_q, ema_q8);

    rep.adc_average  = avg[AvgW-1:0];
    rep.battery_mv   = mv[MvW-1:0];
    rep.filtered_mv  = ema_q8[EmaW-1:8];
    rep.level        = level_q;
    rep.percent      = charge_percent(ema_q8);
    rep.speed_limit  = SpeedQ8[level_q];
    rep.accel_limit  = AccelQ8[level_q];
    rep.max_pwm      = PwmQ8[level_q];
    rep.report_valid = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      scale_q     = ScaleReset;
      alpha_q     = AlphaReset;
      warn_q      = WarnReset;
      crit_q      = CritReset;
      shd_q       = ShdReset;
      hyst_q      = HystReset;
      empty_q     = EmptyReset;
      full_q      = FullReset;
      batch_sum   = '0;
      batch_count = '0;
      ema_q8      = '0;
      ema_primed  = 1'b0;
      level_q     = LvlOk;
      pending_reports.delete();
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("report arrived with none expected");
        end else begin
          want = pending_reports.pop_front();
          check_field("adc_average",  want.adc_average,  out_mon.adc_average);
          check_field("battery_mv",   want.battery_mv,   out_mon.battery_mv);
          check_field("filtered_mv",  want.filtered_mv,  out_mon.filtered_mv);
          check_field("level",        want.level,        out_mon.level);
          check_field("percent",      want.percent,      out_mon.percent);
          check_field("speed_limit",  want.speed_limit,  out_mon.speed_limit);
          check_field("accel_limit",  want.accel_limit,  out_mon.accel_limit);
          check_field("max_pwm",      want.max_pwm,      out_mon.max_pwm);
          check_field("report_valid", want.report_valid, out_mon.report_valid);
        end
      end

      if (in_mon.valid && in_mon.ready)
        if (take_sample(in_mon.sample, in_mon.read_failed, want))
          pending_reports.push_back(want);

      if (cfg_mon.valid && cfg_mon.ready) begin
        // indexes past the register file are dropped
        case (cfg_mon.reg_index)
          RegScale:  scale_q = cfg_mon.wdata[ScaleW-1:0];
          RegAlpha:  alpha_q = cfg_mon.wdata[AlphaW-1:0];
          RegWarnOn: warn_q  = cfg_mon.wdata[MvW-1:0];
          RegCritOn: crit_q  = cfg_mon.wdata[MvW-1:0];
          RegShdOn:  shd_q   = cfg_mon.wdata[MvW-1:0];
          RegHyst:   hyst_q  = cfg_mon.wdata[HystW-1:0];
          RegEmpty:  empty_q = cfg_mon.wdata[MvW-1:0];
          RegFull:   full_q  = cfg_mon.wdata[MvW-1:0];
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= pending_reports.size();
    end
  end

endmodule

### test/tb_battery_level_monitor_core.sv
// Top of the battery level monitor bench: clock, reset, sample and register
// stimulus, report back-pressure, watchdog and verdict.
// Depends on blm_pkg, blm_ifs, battery_level_monitor_core and blm_checker.
module tb_battery_level_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import blm_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 10;
  // covers a batch-closing request's whole sequence, with a margin on top
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 225;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned MaxSample     = 4095;
  // an index beyond the register file, must be ignored
  localparam logic [CfgIdxW-1:0] RegNone = 8'd200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;

  // calm: no gaps on either side; dirty_writes: junk above each register width
  bit calm;
  bit dirty_writes;
  int mean_target;

  blm_in_if  in_if ();
  blm_out_if out_if ();
  blm_cfg_if cfg_if ();

  battery_level_monitor_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  blm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(HalfPeriod) clk = ~clk;

  // Gap length: mostly none, some short, a few long. Shared by both sides.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Report back-pressure: random stalls, none while calm.
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  // Watchdog: a run of cycles with no handshake on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One sample request. Valid is held high straight into the next request
  // when there is no gap, so it never drops for a single step.
  task automatic push_sample(input logic [SampleW-1:0] smp, input logic failed);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= smp;
    in_if.read_failed <= failed;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop sending and wait until every predicted report has been taken.
  // pending is registered in the checker, hence the first wait.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register write; the caller lowers valid after the last of a run.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val,
                         input int unsigned w);
    logic [CfgDataW-1:0] data;
    data = val;
    if (dirty_writes && w < CfgDataW) data = data | (CfgDataW'($urandom) << w);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Registers change only with the block idle: drained, then settled.
  task automatic load_settings(input cfg_t s, input bit poke_unused);
    drain();
    repeat (SettleCycles) @(posedge clk);
    put_reg(RegScale,  CfgDataW'(s.scale),   ScaleW);
    put_reg(RegAlpha,  CfgDataW'(s.alpha),   AlphaW);
    put_reg(RegWarnOn, CfgDataW'(s.warn_on), MvW);
    put_reg(RegCritOn, CfgDataW'(s.crit_on), MvW);
    put_reg(RegShdOn,  CfgDataW'(s.shd_on),  MvW);
    put_reg(RegHyst,   CfgDataW'(s.hyst),    HystW);
    put_reg(RegEmpty,  CfgDataW'(s.empty),   MvW);
    put_reg(RegFull,   CfgDataW'(s.full),    MvW);
    if (poke_unused) put_reg(RegNone, CfgDataW'($urandom), 0);
    cfg_if.valid <= 1'b0;
  endtask

  // Thresholds mostly ordered shutdown < critical < warn so the level walks
  // through every state; now and then anything the fields hold.
  function automatic cfg_t random_settings();
    cfg_t s;
    s.scale = ($urandom_range(0, 3) == 0) ? ScaleW'($urandom)
                                          : ScaleW'($urandom_range(150000, 262143));
    s.alpha = ($urandom_range(0, 3) == 0) ? AlphaW'($urandom)
                                          : AlphaW'($urandom_range(8000, 65536));
    s.shd_on  = MvW'($urandom_range(4000, 12000));
    s.crit_on = s.shd_on + MvW'($urandom_range(0, 1500));
    s.warn_on = s.crit_on + MvW'($urandom_range(0, 1500));
    if ($urandom_range(0, 4) == 0) begin
      s.warn_on = MvW'($urandom);
      s.crit_on = MvW'($urandom);
      s.shd_on  = MvW'($urandom);
    end
    s.hyst  = HystW'($urandom);
    s.empty = MvW'($urandom_range(3000, 9000));
    s.full  = s.empty + MvW'($urandom_range(1, 7000));
    if ($urandom_range(0, 4) == 0) begin
      // full at or below empty now and then
      s.empty = MvW'($urandom);
      s.full  = MvW'($urandom);
    end
    return s;
  endfunction

  // Batches of samples clustered round a wandering mean, so the filtered
  // voltage drifts across the thresholds. A stray failed read breaks a batch
  // now and then. Stops only on a batch boundary to keep batches aligned.
  task automatic run_battery_traffic(input int unsigned n_items);
    int unsigned sent, spread, k;
    int v;
    bit failed;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) mean_target = $urandom_range(0, MaxSample);
      else mean_target = mean_target + $urandom_range(0, 600) - 300;
      if (mean_target < 0) mean_target = 0;
      if (mean_target > MaxSample) mean_target = MaxSample;
      spread = ($urandom_range(0, 9) == 0) ? MaxSample : $urandom_range(0, 60);
      for (k = 0; k < SamplesPerReport; k++) begin
        v = mean_target + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > MaxSample) v = MaxSample;
        failed = ($urandom_range(0, 199) == 0);
        push_sample(SampleW'(v), failed);
        sent++;
        if (failed) break;
      end
      // hold the sender until the pipeline is empty now and then
      if ($urandom_range(0, 11) == 0) drain();
    end
  endtask

  initial begin
    cfg_t s;
    int unsigned phase;
    calm         = 1'b0;
    dirty_writes = 1'b0;
    mean_target  = 3000;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.read_failed <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.reg_index  <= '0;
    cfg_if.wdata      <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset register values.
    // failed read on an empty batch: fallback report at once
    push_sample(SampleW'(MaxSample), 1'b1);
    // partial batch thrown away by a failed read; no report until then
    push_sample('0, 1'b0);
    push_sample(SampleW'(MaxSample), 1'b0);
    push_sample(12'd1234, 1'b0);
    push_sample('0, 1'b1);
    // full-scale batch; its report loads the filter directly
    repeat (SamplesPerReport) push_sample(SampleW'(MaxSample), 1'b0);

    for (phase = 0; phase < NumPhases; phase++) begin
      calm         = (phase == 3 || phase == 6);
      dirty_writes = (phase >= 5);
      case (phase)
        0: s = '{scale: '1, alpha: 17'd65536, warn_on: '1, crit_on: '1, shd_on: '1,
                 hyst: '1, empty: '0, full: '1};
        // all zero: no scaling, frozen filter, full not above empty
        1: s = '0;
        2: s = '{scale: 18'd212853, alpha: 17'd16384, warn_on: 14'd10500,
                 crit_on: 14'd9900, shd_on: 14'd9600, hyst: 10'd200,
                 empty: 14'd9600, full: 14'd12600};
        default: s = random_settings();
      endcase
      load_settings(s, phase >= 5);
      run_battery_traffic(PhaseItems);
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/blm_pkg.sv
rtl/blm_ifs.sv
rtl/blm_regs.sv
rtl/blm_ctrl.sv
rtl/blm_dp.sv
rtl/battery_level_monitor_core.sv
test/blm_checker.sv
test/tb_battery_level_monitor_core.sv
